// File: hdl/spectral_flux_beat_detector_macros.svh
// ----------------------------------------------------------------------------
// Spectral flux beat detector - assertion macros
// Shared property shorthands, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SPECTRAL_FLUX_BEAT_DETECTOR_MACROS_SVH
`define SPECTRAL_FLUX_BEAT_DETECTOR_MACROS_SVH

// same-cycle implication
`define SFBD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfbd: same-cycle check failed");

// next-cycle implication
`define SFBD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfbd: next-cycle check failed");

`endif

// File: hdl/sfbd_pkg.sv
// ----------------------------------------------------------------------------
// sfbd_pkg
// Types, constants and helpers shared by the spectral flux beat detector.
// ----------------------------------------------------------------------------
package sfbd_pkg;

  localparam int FFT_POINTS_DEF     = 512;
  localparam int RING_DEPTH_DEF     = 6;
  localparam int COMPONENT_BITS_DEF = 40;

  localparam int SUM_W   = 49;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam int BASE_W  = 64;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [15:0] TEMPO_ALPHA = 16'd9830;
  localparam logic [15:0] TEMPO_KEEP  = 16'd55706;
  localparam logic [31:0] SMOOTH_RST  = 32'd500 << 16;

  // configuration register indexes
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RISE      = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TEMPO_MIN = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEMPO_MAX = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_BIN = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_BIN  = 4'd7;

  typedef struct packed {
    logic [15:0] alpha;
    logic [15:0] threshold;
    logic [15:0] rise;
    logic [15:0] min_gap;
    logic [15:0] tempo_min;
    logic [15:0] tempo_max;
    logic [7:0]  first_bin;
    logic [7:0]  last_bin;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    alpha: 16'd13107, threshold: 16'd6963, rise: 16'd492, min_gap: 16'd430,
    tempo_min: 16'd430, tempo_max: 16'd800, first_bin: 8'd1, last_bin: 8'd5
  };

  typedef struct packed {
    logic clearing;
    logic idle;
  } back_status_t;

  typedef enum logic [3:0] {
    B_CLEAR, B_IDLE, B_MUL, B_SQRT, B_UPD, B_FRAME, B_EMA, B_BASE,
    B_CMP, B_DEC, B_STR, B_RING, B_MED, B_TEMPO, B_FIN
  } back_state_t;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

endpackage

// File: hdl/spectral_flux_beat_detector.sv
// ----------------------------------------------------------------------------
// spectral_flux_beat_detector
// Bass-band spectral flux onset detector with median tempo tracking.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid / in_stall): one FFT bin per beat with its bin
//    number, frame_end on the last bin of a frame and the frame time in ms.
//  - Result channel (out_valid / out_stall): one result per frame, issued
//    after the frame_end bin; other bins produce nothing.
//  - Config channel (cfg_valid / cfg_ready, always ready): write while idle.
//  - Per bin: an in-band bin is squared serially, both components at once,
//    then rooted one bit per cycle; out-of-band bins are only popped.
//  - Frame end runs a 17-step EMA, 16-step compares and a 17-step quotient,
//    plus ring update, median search and tempo step when a beat updates the tempo.
//  - A two-entry queue lets bins land while the back end iterates.
//  - After reset all FFT_POINTS/2 entries of the magnitude store are swept
//    to zero; in_stall stays high meanwhile.
//  - A stalled result holds in the output register; the back end waits for
//    the slot before finishing the next frame.
// ----------------------------------------------------------------------------
module spectral_flux_beat_detector
  import sfbd_pkg::*;
#(
  parameter int FFT_POINTS     = FFT_POINTS_DEF,
  parameter int RING_DEPTH     = RING_DEPTH_DEF,
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [COMPONENT_BITS-1:0] in_bin_re,
  input  logic signed [COMPONENT_BITS-1:0] in_bin_im,
  input  logic [8:0]                       in_bin_number,
  input  logic                             in_frame_end,
  input  logic [31:0]                      in_now_ms,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_beat,
  output logic [15:0]                      out_strength,
  output logic [48:0]                      out_bass_sum,
  output logic [48:0]                      out_flux_sum,
  output logic                             out_above_flag,
  output logic                             out_rising_flag,
  output logic                             out_gap_ok,
  output logic [31:0]                      out_tempo_interval,
  output logic [31:0]                      out_last_gap_ms,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [CFG_IDX_W-1:0]             cfg_index,
  input  logic [15:0]                      cfg_data
);

`include "spectral_flux_beat_detector_macros.svh"

  localparam int QW = 2 * COMPONENT_BITS + $clog2(FFT_POINTS / 2) + 34;

  cfg_t         cfg_r, cfg_nxt;
  back_status_t back_stat;
  logic         q_push, q_pop, q_full, q_empty;
  logic [QW-1:0] q_in, q_head;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_ALPHA:     cfg_nxt.alpha     = cfg_data;
        REG_THRESHOLD: cfg_nxt.threshold = cfg_data;
        REG_RISE:      cfg_nxt.rise      = cfg_data;
        REG_MIN_GAP:   cfg_nxt.min_gap   = cfg_data;
        REG_TEMPO_MIN: cfg_nxt.tempo_min = cfg_data;
        REG_TEMPO_MAX: cfg_nxt.tempo_max = cfg_data;
        REG_FIRST_BIN: cfg_nxt.first_bin = cfg_data[7:0];
        REG_LAST_BIN:  cfg_nxt.last_bin  = cfg_data[7:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sfbd_front #(.FFT_POINTS(FFT_POINTS), .COMPONENT_BITS(COMPONENT_BITS)) u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_bin_re     (in_bin_re),
    .in_bin_im     (in_bin_im),
    .in_bin_number (in_bin_number),
    .in_frame_end  (in_frame_end),
    .in_now_ms     (in_now_ms),
    .cfg           (cfg_r),
    .clearing      (back_stat.clearing),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_in)
  );

  sfbd_queue #(.WIDTH(QW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head_data (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  sfbd_back #(
    .FFT_POINTS(FFT_POINTS), .RING_DEPTH(RING_DEPTH), .COMPONENT_BITS(COMPONENT_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .q_empty            (q_empty),
    .q_data             (q_head),
    .q_pop              (q_pop),
    .status             (back_stat),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_beat           (out_beat),
    .out_strength       (out_strength),
    .out_bass_sum       (out_bass_sum),
    .out_flux_sum       (out_flux_sum),
    .out_above_flag     (out_above_flag),
    .out_rising_flag    (out_rising_flag),
    .out_gap_ok         (out_gap_ok),
    .out_tempo_interval (out_tempo_interval),
    .out_last_gap_ms    (out_last_gap_ms)
  );

  `SFBD_ASSERT_IMPL(a_clear_stalls, back_stat.clearing, in_stall)
  `SFBD_ASSERT_IMPL(a_pop_ok, q_pop, !q_empty && back_stat.idle)
  `SFBD_ASSERT_IMPL(a_beat_flags, out_valid && out_beat, out_gap_ok && out_above_flag && out_rising_flag)
  `SFBD_ASSERT_IMPL(a_strength_zero, out_valid && !out_beat, out_strength == '0)
  `SFBD_ASSERT_NEXT(a_clear_once, !back_stat.clearing, !back_stat.clearing)

endmodule

// File: hdl/sfbd_ram.sv
// ----------------------------------------------------------------------------
// sfbd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sfbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hdl/sfbd_queue.sv
// ----------------------------------------------------------------------------
// sfbd_queue
// Short FIFO between the bin classifier and the processing back end.
// ----------------------------------------------------------------------------
module sfbd_queue
  import sfbd_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             full,
  output logic             empty
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0] slot_r [QUEUE_DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [PW:0]      count_r, count_nxt;

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = rptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

  assign head_data = slot_r[rptr_r];
  assign full      = (count_r == (PW+1)'(QUEUE_DEPTH));
  assign empty     = (count_r == '0);

endmodule

// File: hdl/sfbd_front.sv
// ----------------------------------------------------------------------------
// sfbd_front
// Input handshake and bin classification: band membership, address packing.
// ----------------------------------------------------------------------------
module sfbd_front
  import sfbd_pkg::*;
#(
  parameter int FFT_POINTS     = FFT_POINTS_DEF,
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [COMPONENT_BITS-1:0] in_bin_re,
  input  logic signed [COMPONENT_BITS-1:0] in_bin_im,
  input  logic [8:0]                       in_bin_number,
  input  logic                             in_frame_end,
  input  logic [31:0]                      in_now_ms,
  input  cfg_t                             cfg,
  input  logic                             clearing,
  input  logic                             q_full,
  output logic                             q_push,
  output logic [2*COMPONENT_BITS+$clog2(FFT_POINTS/2)+33:0] q_data
);

  localparam int HALF = FFT_POINTS / 2;
  localparam int AW   = $clog2(HALF);

  logic [15:0] bin16, first16, last16;
  logic        in_band;

  always_comb begin
    bin16   = 16'(in_bin_number);
    first16 = (cfg.first_bin == '0) ? 16'd1 : 16'(cfg.first_bin);
    last16  = (16'(cfg.last_bin) > 16'(HALF - 1)) ? 16'(HALF - 1) : 16'(cfg.last_bin);
    in_band = (bin16 >= first16) && (bin16 <= last16) && (bin16 < 16'(HALF));
  end

  assign in_stall = q_full || clearing;
  assign q_push   = in_valid && !in_stall;
  assign q_data   = {in_bin_re, in_bin_im, bin16[AW-1:0], in_band, in_frame_end, in_now_ms};

endmodule

// File: hdl/sfbd_back.sv
// ----------------------------------------------------------------------------
// sfbd_back
// Sequenced datapath: bin magnitude, flux accumulation, frame-end decision,
// tempo tracking and the result register.
// ----------------------------------------------------------------------------
module sfbd_back
  import sfbd_pkg::*;
#(
  parameter int FFT_POINTS     = FFT_POINTS_DEF,
  parameter int RING_DEPTH     = RING_DEPTH_DEF,
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  cfg_t         cfg,
  input  logic         q_empty,
  input  logic [2*COMPONENT_BITS+$clog2(FFT_POINTS/2)+33:0] q_data,
  output logic         q_pop,
  output back_status_t status,
  output logic         out_valid,
  input  logic         out_stall,
  output logic         out_beat,
  output logic [15:0]  out_strength,
  output logic [48:0]  out_bass_sum,
  output logic [48:0]  out_flux_sum,
  output logic         out_above_flag,
  output logic         out_rising_flag,
  output logic         out_gap_ok,
  output logic [31:0]  out_tempo_interval,
  output logic [31:0]  out_last_gap_ms
);

  localparam int HALF  = FFT_POINTS / 2;
  localparam int AW    = $clog2(HALF);
  localparam int CB    = COMPONENT_BITS;
  localparam int RW    = CB + 1;
  localparam int NW    = 2 * RW;
  localparam int ACC_W = 82;
  localparam int CM_W  = 80;
  localparam int DK_W  = 99;
  localparam int RIW   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int FW    = $clog2(RING_DEPTH + 1);

  back_state_t state_r, state_nxt;

  // bin item
  logic [CB-1:0]   re_raw, im_raw, re_abs, im_abs;
  logic [AW-1:0]   q_addr;
  logic            q_band, q_fe;
  logic [31:0]     q_now;
  logic [AW-1:0]   addr_r, addr_nxt, clr_r, clr_nxt;
  logic            fe_r, fe_nxt;
  logic [31:0]     now_r, now_nxt;
  logic [6:0]      cnt_r, cnt_nxt;
  logic [NW-1:0]   sa_r, sa_nxt, sb_r, sb_nxt, sq_r, sq_nxt;
  logic [CB-1:0]   abits_r, abits_nxt, bbits_r, bbits_nxt;
  logic [RW-1:0]   root_r, root_nxt;
  logic [RW:0]     rem_r, rem_nxt;
  logic [RW+2:0]   remx, trial;

  // architectural state
  logic [SUM_W-1:0]  bass_acc_r, bass_acc_nxt, flux_acc_r, flux_acc_nxt;
  logic [SUM_W-1:0]  prev_flux_r, prev_flux_nxt;
  logic [BASE_W-1:0] baseline_r, baseline_nxt;
  logic [31:0]       lbt_r, lbt_nxt, last_gap_r, last_gap_nxt, smooth_r, smooth_nxt;
  logic [15:0]       ring_r [RING_DEPTH];
  logic [15:0]       ring_nxt [RING_DEPTH];
  logic [RIW-1:0]    wp_r, wp_nxt;
  logic [FW-1:0]     fill_r, fill_nxt, tgt_r, tgt_nxt;

  // frame-end work registers
  logic [SUM_W-1:0]  flux_f_r, flux_f_nxt, bass_f_r, bass_f_nxt;
  logic [ACC_W-1:0]  ea_r, ea_nxt, eb_r, eb_nxt, acc_r, acc_nxt;
  logic [16:0]       w1_r, w1_nxt, w2_r, w2_nxt;
  logic [CM_W-1:0]   cm_r, cm_nxt, pt_r, pt_nxt, pr_r, pr_nxt;
  logic [15:0]       tb_r, tb_nxt, rb_r, rb_nxt;
  logic [DK_W-1:0]   dk_r, dk_nxt, prod_r, prod_nxt, tst;
  logic [16:0]       qt_r, qt_nxt;
  logic              above_r, above_nxt, rising_r, rising_nxt, gapok_r, gapok_nxt;
  logic              beat_r, beat_nxt;
  logic [15:0]       med_r, med_nxt, cand;
  logic [FW:0]       n_less, n_eq;
  logic [31:0]       iv, gap;
  logic [BASE_W-1:0] f14, base_in, base_new;
  logic [SUM_W-1:0]  diff, mag49, prev49;
  logic [49:0]       tempo_acc;

  // result register
  logic        ov_r, ov_nxt, ob_r, ob_nxt, oa_r, oa_nxt, or_r, or_nxt, og_r, og_nxt;
  logic [15:0] os_r, os_nxt;
  logic [48:0] obs_r, obs_nxt, ofs_r, ofs_nxt;
  logic [31:0] ot_r, ot_nxt, olg_r, olg_nxt;

  // magnitude store
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr;
  logic [RW-1:0]     ram_wdata, ram_rdata;

  sfbd_ram #(.WIDTH(RW), .DEPTH(HALF)) u_mag_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (q_addr),
    .rd_data (ram_rdata)
  );

  assign {re_raw, im_raw, q_addr, q_band, q_fe, q_now} = q_data;
  assign re_abs = re_raw[CB-1] ? (~re_raw + 1'b1) : re_raw;
  assign im_abs = im_raw[CB-1] ? (~im_raw + 1'b1) : im_raw;

  always_comb begin
    state_nxt = state_r;
    addr_nxt = addr_r; clr_nxt = clr_r; fe_nxt = fe_r; now_nxt = now_r; cnt_nxt = cnt_r;
    sa_nxt = sa_r; sb_nxt = sb_r; sq_nxt = sq_r; abits_nxt = abits_r; bbits_nxt = bbits_r;
    root_nxt = root_r; rem_nxt = rem_r;
    bass_acc_nxt = bass_acc_r; flux_acc_nxt = flux_acc_r; prev_flux_nxt = prev_flux_r;
    baseline_nxt = baseline_r; lbt_nxt = lbt_r; last_gap_nxt = last_gap_r;
    smooth_nxt = smooth_r; ring_nxt = ring_r; wp_nxt = wp_r; fill_nxt = fill_r;
    tgt_nxt = tgt_r;
    flux_f_nxt = flux_f_r; bass_f_nxt = bass_f_r;
    ea_nxt = ea_r; eb_nxt = eb_r; acc_nxt = acc_r; w1_nxt = w1_r; w2_nxt = w2_r;
    cm_nxt = cm_r; pt_nxt = pt_r; pr_nxt = pr_r; tb_nxt = tb_r; rb_nxt = rb_r;
    dk_nxt = dk_r; prod_nxt = prod_r; qt_nxt = qt_r;
    above_nxt = above_r; rising_nxt = rising_r; gapok_nxt = gapok_r; beat_nxt = beat_r;
    med_nxt = med_r;
    ov_nxt = ov_r && out_stall;
    ob_nxt = ob_r; oa_nxt = oa_r; or_nxt = or_r; og_nxt = og_r; os_nxt = os_r;
    obs_nxt = obs_r; ofs_nxt = ofs_r; ot_nxt = ot_r; olg_nxt = olg_r;
    q_pop = 1'b0; ram_re = 1'b0; ram_we = 1'b0;
    ram_waddr = addr_r; ram_wdata = root_r;
    remx = {rem_r, sq_r[NW-1:NW-2]};
    trial = (RW+3)'({root_r, 2'b01});
    mag49 = SUM_W'(root_r);
    prev49 = SUM_W'(ram_rdata);
    f14 = BASE_W'({flux_acc_r, 14'b0});
    base_in = (baseline_r <= BASE_W'(1)) ? f14 : baseline_r;
    base_new = BASE_W'((acc_r + ACC_W'(32768)) >> 16);
    diff = flux_f_r - prev_flux_r;
    gap = now_r - lbt_r;
    tst = prod_r + dk_r;
    iv = gap;
    if (iv < 32'(cfg.tempo_min)) iv = 32'(cfg.tempo_min);
    if (iv > 32'(cfg.tempo_max)) iv = 32'(cfg.tempo_max);
    cand = ring_r[cnt_r[RIW-1:0]];
    n_less = '0;
    n_eq = '0;
    for (int j = 0; j < RING_DEPTH; j++) begin
      if (FW'(j) < fill_r) begin
        n_less = n_less + (FW+1)'(ring_r[j] < cand);
        n_eq   = n_eq + (FW+1)'(ring_r[j] == cand);
      end
    end
    tempo_acc = 50'(smooth_r) * 50'(TEMPO_KEEP) + 50'({med_r, 16'b0}) * 50'(TEMPO_ALPHA)
              + 50'd32768;

    unique case (state_r)
      B_CLEAR: begin
        ram_we = 1'b1; ram_waddr = clr_r; ram_wdata = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(HALF - 1)) state_nxt = B_IDLE;
      end
      B_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1; ram_re = 1'b1;
          addr_nxt = q_addr; fe_nxt = q_fe; now_nxt = q_now;
          sa_nxt = NW'(re_abs); sb_nxt = NW'(im_abs);
          abits_nxt = re_abs; bbits_nxt = im_abs;
          sq_nxt = '0; cnt_nxt = '0;
          if (q_band) state_nxt = B_MUL;
          else if (q_fe) state_nxt = B_FRAME;
        end
      end
      B_MUL: begin
        // shift-add squares of both components at once
        sq_nxt = sq_r + (abits_r[0] ? sa_r : '0) + (bbits_r[0] ? sb_r : '0);
        sa_nxt = sa_r << 1; sb_nxt = sb_r << 1;
        abits_nxt = abits_r >> 1; bbits_nxt = bbits_r >> 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 7'(CB - 1)) begin
          state_nxt = B_SQRT; cnt_nxt = '0; root_nxt = '0; rem_nxt = '0;
        end
      end
      B_SQRT: begin
        // one root bit per step, two radicand bits consumed
        if (remx >= trial) begin
          rem_nxt = (RW+1)'(remx - trial);
          root_nxt = {root_r[RW-2:0], 1'b1};
        end else begin
          rem_nxt = remx[RW:0];
          root_nxt = {root_r[RW-2:0], 1'b0};
        end
        sq_nxt = sq_r << 2;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 7'(RW - 1)) state_nxt = B_UPD;
      end
      B_UPD: begin
        bass_acc_nxt = sat_add(bass_acc_r, mag49);
        if (mag49 > prev49) flux_acc_nxt = sat_add(flux_acc_r, mag49 - prev49);
        ram_we = 1'b1;
        state_nxt = fe_r ? B_FRAME : B_IDLE;
      end
      B_FRAME: begin
        flux_f_nxt = flux_acc_r; bass_f_nxt = bass_acc_r;
        flux_acc_nxt = '0; bass_acc_nxt = '0;
        ea_nxt = ACC_W'(base_in); eb_nxt = ACC_W'(f14);
        w1_nxt = 17'h10000 - {1'b0, cfg.alpha}; w2_nxt = {1'b0, cfg.alpha};
        acc_nxt = '0; cnt_nxt = '0;
        state_nxt = B_EMA;
      end
      B_EMA: begin
        acc_nxt = acc_r + (w1_r[0] ? ea_r : '0) + (w2_r[0] ? eb_r : '0);
        ea_nxt = ea_r << 1; eb_nxt = eb_r << 1;
        w1_nxt = w1_r >> 1; w2_nxt = w2_r >> 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 7'd16) state_nxt = B_BASE;
      end
      B_BASE: begin
        baseline_nxt = base_new;
        cm_nxt = CM_W'(base_new); tb_nxt = cfg.threshold; rb_nxt = cfg.rise;
        pt_nxt = '0; pr_nxt = '0; cnt_nxt = '0;
        state_nxt = B_CMP;
      end
      B_CMP: begin
        pt_nxt = pt_r + (tb_r[0] ? cm_r : '0);
        pr_nxt = pr_r + (rb_r[0] ? cm_r : '0);
        cm_nxt = cm_r << 1; tb_nxt = tb_r >> 1; rb_nxt = rb_r >> 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 7'd15) state_nxt = B_DEC;
      end
      B_DEC: begin
        above_nxt  = CM_W'({flux_f_r, 26'b0}) > pt_r;
        rising_nxt = (flux_f_r > prev_flux_r) && (CM_W'({diff, 26'b0}) > pr_r);
        gapok_nxt  = gap >= 32'(cfg.min_gap);
        beat_nxt   = gapok_nxt && above_nxt && rising_nxt;
        // divisor (baseline + eps) * threshold, aligned to the top quotient bit
        dk_nxt = DK_W'(pt_r + CM_W'({cfg.threshold, 4'b0})) << 16;
        prod_nxt = '0; qt_nxt = '0; cnt_nxt = '0;
        state_nxt = B_STR;
      end
      B_STR: begin
        if (tst <= DK_W'({flux_f_r, 42'b0})) begin
          prod_nxt = tst; qt_nxt = {qt_r[15:0], 1'b1};
        end else begin
          qt_nxt = {qt_r[15:0], 1'b0};
        end
        dk_nxt = dk_r >> 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 7'd16) state_nxt = (beat_r && lbt_r != '0) ? B_RING : B_FIN;
      end
      B_RING: begin
        ring_nxt[wp_r] = iv[15:0];
        wp_nxt = (wp_r == RIW'(RING_DEPTH - 1)) ? '0 : wp_r + 1'b1;
        fill_nxt = (fill_r < FW'(RING_DEPTH)) ? fill_r + 1'b1 : fill_r;
        tgt_nxt = fill_nxt >> 1;
        cnt_nxt = '0;
        state_nxt = B_MED;
      end
      B_MED: begin
        // candidate holds the sorted slot when its rank range covers the target
        if ((FW'(cnt_r) < fill_r) && ((FW+1)'(tgt_r) >= n_less)
            && ((FW+1)'(tgt_r) < n_less + n_eq)) begin
          med_nxt = cand;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 7'(RING_DEPTH - 1)) state_nxt = B_TEMPO;
      end
      B_TEMPO: begin
        smooth_nxt = tempo_acc[47:16];
        state_nxt = B_FIN;
      end
      B_FIN: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          ob_nxt = beat_r; oa_nxt = above_r; or_nxt = rising_r; og_nxt = gapok_r;
          os_nxt = (beat_r && qt_r[16]) ? qt_r[15:0] : '0;
          obs_nxt = bass_f_r; ofs_nxt = flux_f_r; ot_nxt = smooth_r;
          olg_nxt = last_gap_r;
          if (beat_r) begin
            last_gap_nxt = (lbt_r != '0) ? gap : '0;
            olg_nxt = last_gap_nxt;
            lbt_nxt = now_r;
          end
          prev_flux_nxt = flux_f_r;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_CLEAR; clr_r <= '0; cnt_r <= '0;
      bass_acc_r <= '0; flux_acc_r <= '0; prev_flux_r <= '0; baseline_r <= '0;
      lbt_r <= '0; last_gap_r <= '0; smooth_r <= SMOOTH_RST;
      wp_r <= '0; fill_r <= '0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; clr_r <= clr_nxt; cnt_r <= cnt_nxt;
      bass_acc_r <= bass_acc_nxt; flux_acc_r <= flux_acc_nxt;
      prev_flux_r <= prev_flux_nxt; baseline_r <= baseline_nxt;
      lbt_r <= lbt_nxt; last_gap_r <= last_gap_nxt; smooth_r <= smooth_nxt;
      wp_r <= wp_nxt; fill_r <= fill_nxt; ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt; fe_r <= fe_nxt; now_r <= now_nxt;
    sa_r <= sa_nxt; sb_r <= sb_nxt; sq_r <= sq_nxt; abits_r <= abits_nxt;
    bbits_r <= bbits_nxt; root_r <= root_nxt; rem_r <= rem_nxt;
    ring_r <= ring_nxt; tgt_r <= tgt_nxt;
    flux_f_r <= flux_f_nxt; bass_f_r <= bass_f_nxt;
    ea_r <= ea_nxt; eb_r <= eb_nxt; acc_r <= acc_nxt; w1_r <= w1_nxt; w2_r <= w2_nxt;
    cm_r <= cm_nxt; pt_r <= pt_nxt; pr_r <= pr_nxt; tb_r <= tb_nxt; rb_r <= rb_nxt;
    dk_r <= dk_nxt; prod_r <= prod_nxt; qt_r <= qt_nxt;
    above_r <= above_nxt; rising_r <= rising_nxt; gapok_r <= gapok_nxt;
    beat_r <= beat_nxt; med_r <= med_nxt;
    ob_r <= ob_nxt; oa_r <= oa_nxt; or_r <= or_nxt; og_r <= og_nxt; os_r <= os_nxt;
    obs_r <= obs_nxt; ofs_r <= ofs_nxt; ot_r <= ot_nxt; olg_r <= olg_nxt;
  end

  assign status.clearing = (state_r == B_CLEAR);
  assign status.idle     = (state_r == B_IDLE);

  assign out_valid          = ov_r;
  assign out_beat           = ob_r;
  assign out_strength       = os_r;
  assign out_bass_sum       = obs_r;
  assign out_flux_sum       = ofs_r;
  assign out_above_flag     = oa_r;
  assign out_rising_flag    = or_r;
  assign out_gap_ok         = og_r;
  assign out_tempo_interval = ot_r;
  assign out_last_gap_ms    = olg_r;

endmodule
